// ===== design/cfbc_pkg.sv =====
package cfbc_pkg;

    localparam int MAX_WIDTH_DEF  = 4096;
    localparam int COUNT_BITS_DEF = 25;

    localparam int PIX_W      = 8;
    localparam int IMG_W      = 13;
    localparam int THR_W      = 9;
    localparam int MIN_W      = 25;
    localparam int FIELD_W    = 25;
    localparam int DOM_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 25;
    localparam int BAND_W     = 2;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 208;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_THRESHOLD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_THRESHOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DOMINANT   = 2'd3;

    localparam logic [IMG_W-1:0] IMAGE_WIDTH_RST = 13'd640;
    localparam logic [THR_W-1:0] THRESHOLD_RST   = 9'd179;
    localparam logic [MIN_W-1:0] MIN_DOMINANT_RST = 25'd500;

    localparam logic [BAND_W-1:0] BAND_LEFT   = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MIDDLE = 2'd1;
    localparam logic [BAND_W-1:0] BAND_RIGHT  = 2'd2;

    localparam logic [DOM_W-1:0] DOM_NONE = 2'd0;
    localparam logic [DOM_W-1:0] DOM_RED  = 2'd1;
    localparam logic [DOM_W-1:0] DOM_BLUE = 2'd2;

    // ceil(2^21 / 3): exact floor division by three for any operand below 2^21
    localparam logic [19:0] DIV3_MAGIC = 20'd699051;
    localparam int          DIV3_SHIFT = 21;

    typedef struct packed {
        logic                valid;
        logic                red_hit;
        logic                blue_hit;
        logic [BAND_W-1:0]   band;
        logic                last;
    } t_pix_class;

    function automatic logic [17:0] div3(input logic [17:0] x);
        logic [38:0] prod;
        prod = 39'(x) * 39'(DIV3_MAGIC);
        return prod[DIV3_SHIFT+17:DIV3_SHIFT];
    endfunction

    function automatic logic [FIELD_W-1:0] fit_field(input logic [31:0] v);
        return v[FIELD_W-1:0];
    endfunction

endpackage

// ===== design/cfbc_config.sv =====
module cfbc_config #(
    parameter int MAX_WIDTH = cfbc_pkg::MAX_WIDTH_DEF,
    localparam int WB = $clog2(MAX_WIDTH + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cfbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [cfbc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    output logic [WB-1:0]                    o_width,
    output logic [WB-1:0]                    o_bound1,
    output logic [WB-1:0]                    o_bound2,
    output logic [cfbc_pkg::THR_W-1:0]       o_red_thr,
    output logic [cfbc_pkg::THR_W-1:0]       o_blue_thr,
    output logic [cfbc_pkg::MIN_W-1:0]       o_min_count
);
    import cfbc_pkg::*;

    logic [IMG_W-1:0] r_image_width;
    logic [THR_W-1:0] r_red_thr;
    logic [THR_W-1:0] r_blue_thr;
    logic [MIN_W-1:0] r_min_count;
    logic [WB-1:0]    r_width;
    logic [WB-1:0]    r_bound1;
    logic [WB-1:0]    r_bound2;
    logic [31:0]      n_width;
    logic [17:0]      n_third;
    logic [17:0]      n_two_thirds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_red_thr     <= THRESHOLD_RST;
            r_blue_thr    <= THRESHOLD_RST;
            r_min_count   <= MIN_DOMINANT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_IMAGE_WIDTH:    r_image_width <= i_cfg_wdata[IMG_W-1:0];
                CFG_RED_THRESHOLD:  r_red_thr     <= i_cfg_wdata[THR_W-1:0];
                CFG_BLUE_THRESHOLD: r_blue_thr    <= i_cfg_wdata[THR_W-1:0];
                CFG_MIN_DOMINANT:   r_min_count   <= i_cfg_wdata[MIN_W-1:0];
                default: ;
            endcase
        end
    end

    // clamp the width to 1..MAX_WIDTH, then derive the band edges
    always_comb begin
        n_width = 32'(r_image_width);
        if (n_width == 32'd0) begin
            n_width = 32'd1;
        end else if (n_width > 32'(MAX_WIDTH)) begin
            n_width = 32'(MAX_WIDTH);
        end
        n_third      = div3(n_width[17:0]);
        n_two_thirds = div3({n_width[16:0], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        r_width  <= n_width[WB-1:0];
        r_bound1 <= n_third[WB-1:0];
        r_bound2 <= n_two_thirds[WB-1:0];
    end

    assign o_width     = r_width;
    assign o_bound1    = r_bound1;
    assign o_bound2    = r_bound2;
    assign o_red_thr   = r_red_thr;
    assign o_blue_thr  = r_blue_thr;
    assign o_min_count = r_min_count;

endmodule

// ===== design/cfbc_classify.sv =====
module cfbc_classify #(
    parameter int MAX_WIDTH = cfbc_pkg::MAX_WIDTH_DEF,
    localparam int WB = $clog2(MAX_WIDTH + 1),
    localparam int CB = $clog2(MAX_WIDTH)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic [cfbc_pkg::PIX_W-1:0]   i_red,
    input  logic [cfbc_pkg::PIX_W-1:0]   i_green,
    input  logic [cfbc_pkg::PIX_W-1:0]   i_blue,
    input  logic                         i_last,
    input  logic [WB-1:0]                i_width,
    input  logic [WB-1:0]                i_bound1,
    input  logic [WB-1:0]                i_bound2,
    input  logic [cfbc_pkg::THR_W-1:0]   i_red_thr,
    input  logic [cfbc_pkg::THR_W-1:0]   i_blue_thr,
    output cfbc_pkg::t_pix_class         o_pix
);
    import cfbc_pkg::*;

    logic             r_in_valid;
    logic [PIX_W-1:0] r_red;
    logic [PIX_W-1:0] r_green;
    logic [PIX_W-1:0] r_blue;
    logic             r_last;
    logic [CB-1:0]    r_col;
    t_pix_class       r_pix;

    logic [9:0]       sum;
    logic [18:0]      red_scaled;
    logic [18:0]      blue_scaled;
    logic [18:0]      red_limit;
    logic [18:0]      blue_limit;
    logic [WB-1:0]    col_ext;
    logic [WB-1:0]    col_inc;
    t_pix_class       n_pix;
    logic [CB-1:0]    n_col;

    // input word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
            r_last  <= i_last;
        end
    end

    always_comb begin
        sum         = 10'(r_red) + 10'(r_green) + 10'(r_blue);
        red_scaled  = 19'({r_red, 8'h00});
        blue_scaled = 19'({r_blue, 8'h00});
        red_limit   = 19'(i_red_thr) * 19'(sum);
        blue_limit  = 19'(i_blue_thr) * 19'(sum);
        col_ext     = WB'(r_col);
        col_inc     = col_ext + WB'(1);

        n_pix.valid    = r_in_valid;
        n_pix.last     = r_last;
        n_pix.red_hit  = red_scaled > red_limit;
        n_pix.blue_hit = !n_pix.red_hit && (blue_scaled > blue_limit);
        if (col_ext < i_bound1) begin
            n_pix.band = BAND_LEFT;
        end else if (col_ext < i_bound2) begin
            n_pix.band = BAND_MIDDLE;
        end else begin
            n_pix.band = BAND_RIGHT;
        end

        // wrap at the row end, restart on the frame's last word
        if (r_last || col_inc >= i_width) begin
            n_col = '0;
        end else begin
            n_col = col_inc[CB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_pix.valid <= 1'b0;
        end else if (i_adv) begin
            r_pix.valid <= n_pix.valid;
            if (r_in_valid) begin
                r_col <= n_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_pix.red_hit  <= n_pix.red_hit;
            r_pix.blue_hit <= n_pix.blue_hit;
            r_pix.band     <= n_pix.band;
            r_pix.last     <= n_pix.last;
        end
    end

    assign o_pix = r_pix;

endmodule

// ===== design/cfbc_band_count.sv =====
module cfbc_band_count #(
    parameter int COUNT_BITS = cfbc_pkg::COUNT_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_adv,
    input  cfbc_pkg::t_pix_class   i_pix,
    output logic                   o_snap_valid,
    output logic [COUNT_BITS-1:0]  o_red_snap [3],
    output logic [COUNT_BITS-1:0]  o_blue_snap [3]
);
    import cfbc_pkg::*;

    logic [COUNT_BITS-1:0] r_red_cnt  [3];
    logic [COUNT_BITS-1:0] r_blue_cnt [3];
    logic [COUNT_BITS-1:0] r_red_snap [3];
    logic [COUNT_BITS-1:0] r_blue_snap [3];
    logic                  r_snap_valid;
    logic [COUNT_BITS-1:0] n_red_cnt  [3];
    logic [COUNT_BITS-1:0] n_blue_cnt [3];

    // saturating increment of the counter that the word's class and band select
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_red_cnt[i]  = r_red_cnt[i];
            n_blue_cnt[i] = r_blue_cnt[i];
            if (i_pix.band == BAND_W'(i)) begin
                if (i_pix.red_hit && (r_red_cnt[i] != '1)) begin
                    n_red_cnt[i] = r_red_cnt[i] + COUNT_BITS'(1);
                end
                if (i_pix.blue_hit && (r_blue_cnt[i] != '1)) begin
                    n_blue_cnt[i] = r_blue_cnt[i] + COUNT_BITS'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_red_cnt[i]  <= '0;
                r_blue_cnt[i] <= '0;
            end
            r_snap_valid <= 1'b0;
        end else if (i_adv) begin
            r_snap_valid <= i_pix.valid && i_pix.last;
            if (i_pix.valid) begin
                for (int i = 0; i < 3; i++) begin
                    r_red_cnt[i]  <= i_pix.last ? '0 : n_red_cnt[i];
                    r_blue_cnt[i] <= i_pix.last ? '0 : n_blue_cnt[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_pix.valid && i_pix.last) begin
            for (int i = 0; i < 3; i++) begin
                r_red_snap[i]  <= n_red_cnt[i];
                r_blue_snap[i] <= n_blue_cnt[i];
            end
        end
    end

    assign o_snap_valid = r_snap_valid;
    assign o_red_snap   = r_red_snap;
    assign o_blue_snap  = r_blue_snap;

endmodule

// ===== design/cfbc_result.sv =====
module cfbc_result #(
    parameter int COUNT_BITS = cfbc_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_snap_valid,
    input  logic [COUNT_BITS-1:0]             i_red_snap [3],
    input  logic [COUNT_BITS-1:0]             i_blue_snap [3],
    input  logic [cfbc_pkg::MIN_W-1:0]        i_min_count,
    input  logic                              i_m_axis_tready,
    output logic                              o_adv,
    output logic                              o_m_axis_tvalid,
    output logic [cfbc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import cfbc_pkg::*;

    localparam int SUM_W = COUNT_BITS + 2;

    logic                  r_out_valid;
    logic [FIELD_W-1:0]    r_red_field  [3];
    logic [FIELD_W-1:0]    r_blue_field [3];
    logic [FIELD_W-1:0]    r_red_total;
    logic [FIELD_W-1:0]    r_blue_total;
    logic [DOM_W-1:0]      r_dom [3];

    logic                  adv;
    logic [SUM_W-1:0]      red_sum;
    logic [SUM_W-1:0]      blue_sum;
    logic [COUNT_BITS-1:0] red_sat;
    logic [COUNT_BITS-1:0] blue_sat;
    logic [COUNT_BITS-1:0] best  [3];
    logic [DOM_W-1:0]      code  [3];
    logic [DOM_W-1:0]      n_dom [3];

    // hold the pipe only while a finished frame waits behind an untaken word
    assign adv = !(i_snap_valid && r_out_valid && !i_m_axis_tready);

    always_comb begin
        red_sum  = SUM_W'(i_red_snap[0]) + SUM_W'(i_red_snap[1]) + SUM_W'(i_red_snap[2]);
        blue_sum = SUM_W'(i_blue_snap[0]) + SUM_W'(i_blue_snap[1])
                 + SUM_W'(i_blue_snap[2]);
        red_sat  = (red_sum[SUM_W-1:COUNT_BITS] != 2'b00) ? '1 : red_sum[COUNT_BITS-1:0];
        blue_sat = (blue_sum[SUM_W-1:COUNT_BITS] != 2'b00) ? '1 : blue_sum[COUNT_BITS-1:0];

        // red wins ties; an empty band gives no class
        for (int i = 0; i < 3; i++) begin
            if (i_blue_snap[i] > i_red_snap[i]) begin
                best[i] = i_blue_snap[i];
                code[i] = DOM_BLUE;
            end else begin
                best[i] = i_red_snap[i];
                code[i] = (i_red_snap[i] != '0) ? DOM_RED : DOM_NONE;
            end
            n_dom[i] = (32'(best[i]) > 32'(i_min_count)) ? code[i] : DOM_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_snap_valid && adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_snap_valid && adv) begin
            for (int i = 0; i < 3; i++) begin
                r_red_field[i]  <= fit_field(32'(i_red_snap[i]));
                r_blue_field[i] <= fit_field(32'(i_blue_snap[i]));
                r_dom[i]        <= n_dom[i];
            end
            r_red_total  <= fit_field(32'(red_sat));
            r_blue_total <= fit_field(32'(blue_sat));
        end
    end

    assign o_adv           = adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {2'b00, r_dom[2], r_dom[1], r_dom[0],
                              r_blue_total, r_red_total,
                              r_blue_field[2], r_blue_field[1], r_blue_field[0],
                              r_red_field[2], r_red_field[1], r_red_field[0]};

endmodule

// ===== design/color_fraction_band_counter.sv =====
// Channel   Dir  Signals                                   Moves
// s_axis    in   i_s_axis_tvalid/o_s_axis_tready/tdata/tlast one pixel word
// m_axis    out  o_m_axis_tvalid/i_m_axis_tready/tdata     one frame result word
// cfg       in   i_cfg_wr_en/i_cfg_index/i_cfg_wdata       register write
//
// One pixel word is taken every cycle while the input is not stalled; a word
// passes an input register, a classify stage, the band counters and the result
// register on the way to its frame's result word.
// Reset (synchronous, low) clears the column, the counters and all valids.
// The input stalls only while a finished frame waits behind an untaken result.
module color_fraction_band_counter #(
    parameter int MAX_WIDTH  = cfbc_pkg::MAX_WIDTH_DEF,
    parameter int COUNT_BITS = cfbc_pkg::COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // red [7:0], green [15:8], blue [23:16]
    input  logic [cfbc_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  logic                              i_s_axis_tlast,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // red_left, red_middle, red_right, blue_left, blue_middle, blue_right,
    // red_total, blue_total (25 bits each), dominant_left, dominant_middle,
    // dominant_right (2 bits each), zero pad
    output logic [cfbc_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                              i_cfg_wr_en,
    input  logic [cfbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cfbc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata
);
    import cfbc_pkg::*;

    localparam int WB = $clog2(MAX_WIDTH + 1);

    logic [WB-1:0]         width;
    logic [WB-1:0]         bound1;
    logic [WB-1:0]         bound2;
    logic [THR_W-1:0]      red_thr;
    logic [THR_W-1:0]      blue_thr;
    logic [MIN_W-1:0]      min_count;
    logic                  adv;
    t_pix_class            pix;
    logic                  snap_valid;
    logic [COUNT_BITS-1:0] red_snap  [3];
    logic [COUNT_BITS-1:0] blue_snap [3];

    cfbc_config #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_config (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_width     (width),
        .o_bound1    (bound1),
        .o_bound2    (bound2),
        .o_red_thr   (red_thr),
        .o_blue_thr  (blue_thr),
        .o_min_count (min_count)
    );

    cfbc_classify #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_classify (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_valid    (i_s_axis_tvalid),
        .i_red      (i_s_axis_tdata[PIX_W-1:0]),
        .i_green    (i_s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_blue     (i_s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .i_last     (i_s_axis_tlast),
        .i_width    (width),
        .i_bound1   (bound1),
        .i_bound2   (bound2),
        .i_red_thr  (red_thr),
        .i_blue_thr (blue_thr),
        .o_pix      (pix)
    );

    cfbc_band_count #(
        .COUNT_BITS (COUNT_BITS)
    ) u_band_count (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_pix        (pix),
        .o_snap_valid (snap_valid),
        .o_red_snap   (red_snap),
        .o_blue_snap  (blue_snap)
    );

    cfbc_result #(
        .COUNT_BITS (COUNT_BITS)
    ) u_result (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_snap_valid    (snap_valid),
        .i_red_snap      (red_snap),
        .i_blue_snap     (blue_snap),
        .i_min_count     (min_count),
        .i_m_axis_tready (i_m_axis_tready),
        .o_adv           (adv),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    assign o_s_axis_tready = adv;

endmodule

// ===== tb/color_fraction_band_counter_tb.sv =====
`timescale 1ns / 1ps

module color_fraction_band_counter_tb;
    import cfbc_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 10;
    localparam int          ITEM_TARGET  = 1850;
    localparam int          LONG_FRAME   = 1370;
    localparam logic [24:0] COUNT_MAX    = 25'h1FFFFFF;

    // dominant codes above the eight counts: matches the tdata layout bit for bit
    typedef struct packed {
        logic [2:0][DOM_W-1:0]   dom;
        logic [7:0][FIELD_W-1:0] count;
    } frame_result_t;

    class frame_tally;
        logic [IMG_W-1:0]   image_width;
        logic [THR_W-1:0]   red_thr;
        logic [THR_W-1:0]   blue_thr;
        logic [MIN_W-1:0]   min_dom;
        logic [IMG_W-1:0]   column;
        logic [FIELD_W-1:0] red_cnt[3];
        logic [FIELD_W-1:0] blue_cnt[3];
        frame_result_t      awaited[$];
        string              field_label[11];
        int unsigned        failures;
        int unsigned        frames_done;

        function new();
            image_width = IMAGE_WIDTH_RST;
            red_thr     = THRESHOLD_RST;
            blue_thr    = THRESHOLD_RST;
            min_dom     = MIN_DOMINANT_RST;
            column      = '0;
            for (int i = 0; i < 3; i++) begin
                red_cnt[i]  = '0;
                blue_cnt[i] = '0;
            end
            field_label = '{"red_left", "red_middle", "red_right", "blue_left",
                            "blue_middle", "blue_right", "red_total", "blue_total",
                            "dominant_left", "dominant_middle", "dominant_right"};
            failures    = 0;
            frames_done = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:    image_width = val[IMG_W-1:0];
                CFG_RED_THRESHOLD:  red_thr     = val[THR_W-1:0];
                CFG_BLUE_THRESHOLD: blue_thr    = val[THR_W-1:0];
                CFG_MIN_DOMINANT:   min_dom     = val[MIN_W-1:0];
                default: ;
            endcase
        endfunction

        function void take_pixel(logic [IN_TDATA_W-1:0] rgb, logic last);
            logic [9:0]         sum;
            logic [19:0]        red_scaled;
            logic [19:0]        blue_scaled;
            logic [19:0]        red_bar;
            logic [19:0]        blue_bar;
            logic [IMG_W-1:0]   w;
            logic [13:0]        w1;
            logic [13:0]        w2;
            logic [BAND_W-1:0]  band;
            logic [26:0]        red_sum;
            logic [26:0]        blue_sum;
            logic [FIELD_W-1:0] best;
            logic [DOM_W-1:0]   code;
            frame_result_t      res;

            sum         = 10'(rgb[7:0]) + 10'(rgb[15:8]) + 10'(rgb[23:16]);
            red_scaled  = 20'(rgb[7:0]) << 8;
            blue_scaled = 20'(rgb[23:16]) << 8;
            red_bar     = 20'(red_thr) * 20'(sum);
            blue_bar    = 20'(blue_thr) * 20'(sum);

            if (image_width == '0)
                w = 13'd1;
            else if (image_width > MAX_WIDTH_DEF)
                w = 13'(MAX_WIDTH_DEF);
            else
                w = image_width;
            w1 = 14'(w) / 14'd3;
            w2 = (14'(w) * 14'd2) / 14'd3;

            if (14'(column) < w1)
                band = BAND_LEFT;
            else if (14'(column) < w2)
                band = BAND_MIDDLE;
            else
                band = BAND_RIGHT;

            if (red_scaled > red_bar) begin
                if (red_cnt[band] != COUNT_MAX) red_cnt[band] = red_cnt[band] + 1'b1;
            end else if (blue_scaled > blue_bar) begin
                if (blue_cnt[band] != COUNT_MAX) blue_cnt[band] = blue_cnt[band] + 1'b1;
            end

            // a column left beyond a narrowed width still wraps after this pixel
            if (14'(column) + 14'd1 >= 14'(w))
                column = '0;
            else
                column = column + 1'b1;

            if (!last) return;

            red_sum  = '0;
            blue_sum = '0;
            for (int i = 0; i < 3; i++) begin
                res.count[i]     = red_cnt[i];
                res.count[3 + i] = blue_cnt[i];
                red_sum          = red_sum + 27'(red_cnt[i]);
                blue_sum         = blue_sum + 27'(blue_cnt[i]);
                // red wins ties: blue must be strictly above
                best = '0;
                code = DOM_NONE;
                if (red_cnt[i] > best) begin
                    best = red_cnt[i];
                    code = DOM_RED;
                end
                if (blue_cnt[i] > best) begin
                    best = blue_cnt[i];
                    code = DOM_BLUE;
                end
                res.dom[i] = (best > min_dom) ? code : DOM_NONE;
            end
            res.count[6] = (red_sum > 27'(COUNT_MAX)) ? COUNT_MAX : red_sum[FIELD_W-1:0];
            res.count[7] = (blue_sum > 27'(COUNT_MAX)) ? COUNT_MAX : blue_sum[FIELD_W-1:0];
            awaited.push_back(res);

            for (int i = 0; i < 3; i++) begin
                red_cnt[i]  = '0;
                blue_cnt[i] = '0;
            end
            column = '0;
        endfunction

        function void flag(string what, int unsigned exp_v, int unsigned act_v);
            failures++;
            if (failures <= 10)
                $display("frame %0d %s: expected %0d, got %0d",
                         frames_done, what, exp_v, act_v);
        endfunction

        function void match_result(logic [OUT_TDATA_W-1:0] word);
            frame_result_t got;
            frame_result_t want;

            got = frame_result_t'(word[$bits(frame_result_t)-1:0]);
            if (awaited.size() == 0) begin
                flag("result word with no frame pending", 0, 1);
                return;
            end
            want = awaited.pop_front();
            for (int i = 0; i < 8; i++)
                if (got.count[i] !== want.count[i])
                    flag(field_label[i], want.count[i], got.count[i]);
            for (int i = 0; i < 3; i++)
                if (got.dom[i] !== want.dom[i])
                    flag(field_label[8 + i], want.dom[i], got.dom[i]);
            frames_done++;
        endfunction
    endclass

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     pix_valid = 1'b0;
    logic                     pix_ready;
    logic [IN_TDATA_W-1:0]    pix_data  = '0;
    logic                     pix_last  = 1'b0;
    logic                     res_valid;
    logic                     res_ready = 1'b0;
    logic [OUT_TDATA_W-1:0]   res_data;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    bit          calm      = 1'b0;
    int unsigned hold_left = 0;
    int unsigned n_sent    = 0;
    frame_tally  tally     = new();

    color_fraction_band_counter u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (pix_valid),
        .o_s_axis_tready (pix_ready),
        .i_s_axis_tdata  (pix_data),
        .i_s_axis_tlast  (pix_last),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_wdata     (cfg_wdata)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: random stalls, quiet stretches, and a long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_left != 0) begin
                res_ready <= 1'b0;
                hold_left--;
            end else begin
                res_ready <= calm || ($urandom_range(0, 99) >= 19);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) tally.match_result(res_data);
    end

    function automatic logic [IN_TDATA_W-1:0] rgb(int r, int g, int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    function automatic logic [IN_TDATA_W-1:0] random_pixel();
        case ($urandom_range(0, 9))
            0:       return '0;
            1, 2:    return rgb($urandom_range(128, 255), $urandom_range(0, 60),
                                $urandom_range(0, 60));
            3, 4:    return rgb($urandom_range(0, 60), $urandom_range(0, 60),
                                $urandom_range(128, 255));
            5:       return rgb($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                                $urandom_range(0, 1) * 255);
            default: return IN_TDATA_W'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input logic [IN_TDATA_W-1:0] px, input logic last);
        int unsigned gap;
        gap = 0;
        // random idle gap before the pixel, so that about 19 percent of the input slots stay empty
        while (!calm && $urandom_range(0, 99) < 19) gap++;
        if (gap != 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pix_data  <= px;
        pix_last  <= last;
        do @(posedge clk); while (!pix_ready);
        tally.take_pixel(px, last);
        n_sent++;
    endtask

    // hold the input until every frame result is back and the pipe is empty
    task automatic drain();
        pix_valid <= 1'b0;
        while (tally.awaited.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_settings(input logic [IMG_W-1:0] width,
                                  input logic [THR_W-1:0] red_thr,
                                  input logic [THR_W-1:0] blue_thr,
                                  input logic [MIN_W-1:0] min_count);
        logic [CFG_IDX_W-1:0]  regs[4];
        logic [CFG_DATA_W-1:0] vals[4];
        regs[0] = CFG_IMAGE_WIDTH;
        regs[1] = CFG_RED_THRESHOLD;
        regs[2] = CFG_BLUE_THRESHOLD;
        regs[3] = CFG_MIN_DOMINANT;
        // junk above the register width must be dropped
        vals[0] = {12'($urandom), width};
        vals[1] = {16'($urandom), red_thr};
        vals[2] = {16'($urandom), blue_thr};
        vals[3] = min_count;
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(posedge clk);
            tally.set_register(regs[i], vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int width, input int red_thr, input int blue_thr,
                             input int min_count, input int frames, input int min_len,
                             input int max_len, input bit cut, input bit quiet,
                             input int hold);
        int unsigned len;
        drain();
        write_settings(IMG_W'(width), THR_W'(red_thr), THR_W'(blue_thr),
                       MIN_W'(min_count));
        calm = quiet;
        hold_left = hold;
        for (int f = 0; f < frames; f++) begin
            len = $urandom_range(min_len, max_len);
            // a cut frame carries on into the next phase's settings
            for (int k = 0; k < len; k++)
                send_pixel(random_pixel(), (k == len - 1) && !(cut && f == frames - 1));
        end
        calm = 1'b0;
    endtask

    initial begin
        int width;
        int red_thr;
        int blue_thr;
        int min_count;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: black, white, primaries, threshold ties either side
        send_pixel(rgb(0, 0, 0), 1'b0);
        send_pixel(rgb(255, 255, 255), 1'b0);
        send_pixel(rgb(255, 0, 0), 1'b0);
        send_pixel(rgb(0, 0, 255), 1'b0);
        send_pixel(rgb(0, 255, 0), 1'b0);
        send_pixel(rgb(179, 77, 0), 1'b0);
        send_pixel(rgb(180, 76, 0), 1'b0);
        send_pixel(rgb(0, 77, 179), 1'b0);
        send_pixel(rgb(0, 76, 180), 1'b0);
        send_pixel(rgb(1, 0, 0), 1'b0);
        send_pixel(rgb(0, 0, 1), 1'b0);
        send_pixel(rgb(255, 0, 255), 1'b1);
        send_pixel(rgb(255, 0, 0), 1'b1);
        send_pixel(rgb(0, 0, 0), 1'b1);

        run_phase(3, 179, 179, 0, 6, 1, 30, 1'b1, 1'b0, 0);
        run_phase(0, 128, 128, 0, 5, 1, 20, 1'b0, 1'b0, 0);
        run_phase(8191, 200, 200, 1, 1, LONG_FRAME, LONG_FRAME, 1'b0, 1'b0, 0);
        run_phase(4096, 0, 0, 16777216, 4, 1, 30, 1'b1, 1'b0, 0);
        run_phase(2, 256, 256, 2, 6, 1, 20, 1'b0, 1'b0, 0);
        run_phase(7, 511, 300, 33554431, 5, 1, 30, 1'b0, 1'b0, 0);
        run_phase(10, 100, 150, 3, 40, 1, 3, 1'b0, 1'b0, 300);
        run_phase(5, 179, 179, 0, 10, 1, 30, 1'b0, 1'b1, 0);
        run_phase(1, 90, 60, 1, 6, 1, 20, 1'b0, 1'b0, 0);

        while (n_sent < ITEM_TARGET) begin
            width     = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                    : $urandom_range(1, 24);
            red_thr   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(40, 230);
            blue_thr  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 511)
                                                    : $urandom_range(40, 230);
            min_count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 33554431)
                                                    : $urandom_range(0, 6);
            run_phase(width, red_thr, blue_thr, min_count, $urandom_range(2, 8), 1, 30,
                      $urandom_range(0, 2) == 0, 1'b0, 0);
        end

        drain();
        if (tally.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
